>>> sv/tpsd_pkg.sv
// ----------------------------------------------------------------------------
// tpsd_pkg
// Shared widths, register codes and types of the three-wheel PID speed drive.
// ----------------------------------------------------------------------------
package tpsd_pkg;

  localparam int WHEEL_COUNT = 3;
  localparam int PWM_BITS    = 8;

  // Field and register widths.
  localparam int SPD_W  = 15;
  localparam int GAIN_W = 24;
  localparam int LIM_W  = 36;
  localparam int SUM_W  = 40;

  // Derived datapath widths.
  localparam int ERR_W    = SPD_W + 1;
  localparam int DIF_W    = ERR_W + 1;
  localparam int ACC_W    = SUM_W + 1;
  localparam int ACC_LO_W = SUM_W / 2;
  localparam int ACC_HI_W = SUM_W - ACC_LO_W;
  localparam int PE_W     = GAIN_W + 1 + ERR_W;
  localparam int DE_W     = GAIN_W + 1 + DIF_W;
  localparam int IL_W     = GAIN_W + ACC_LO_W;
  localparam int IH_W     = GAIN_W + 1 + ACC_HI_W;
  localparam int TI_W     = GAIN_W + 1 + SUM_W;
  localparam int PD_W     = DE_W + 1;
  localparam int TOT_W    = TI_W + 1;
  localparam int FRAC_W   = 32;
  localparam int Q_W      = TOT_W - FRAC_W;

  // Pipeline depth: error/state, multiply, partial sums, output register.
  localparam int N_STG = 4;

  // Stream packing.
  localparam int IN_LANE_W   = 2 * SPD_W + 1;
  localparam int IN_TDATA_W  = ((WHEEL_COUNT * IN_LANE_W + 7) / 8) * 8;
  localparam int OUT_LANE_W  = 2 * PWM_BITS;
  localparam int OUT_FIELD_W = WHEEL_COUNT * OUT_LANE_W;
  localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

  // Configuration port.
  localparam int APB_DATA_W = 64;
  localparam int REG_IDX_W  = 2;
  localparam int ADDR_LSB   = 3;
  localparam int PADDR_W    = REG_IDX_W + ADDR_LSB;

  localparam logic [GAIN_W-1:0] PROP_GAIN_RST  = GAIN_W'(335544);
  localparam logic [GAIN_W-1:0] INT_GAIN_RST   = GAIN_W'(16777);
  localparam logic [GAIN_W-1:0] DERIV_GAIN_RST = GAIN_W'(1678);
  localparam logic [LIM_W-1:0]  INT_LIMIT_RST  = LIM_W'(65280000);

  typedef enum logic [REG_IDX_W-1:0] {
    REG_PROP_GAIN  = 2'd0,
    REG_INT_GAIN   = 2'd1,
    REG_DERIV_GAIN = 2'd2,
    REG_INT_LIMIT  = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [GAIN_W-1:0] kp;
    logic [GAIN_W-1:0] ki;
    logic [GAIN_W-1:0] kd;
    logic [LIM_W-1:0]  limit;
  } cfg_t;

  typedef struct packed {
    logic take;    // input request accepted, lane state updates
    logic ld2;     // multiply stage loads
    logic ld3;     // partial sum stage loads
    logic ld_out;  // output register loads
  } pipe_ctl_t;

  typedef struct packed {
    logic signed [TI_W-1:0] ti;
    logic signed [PD_W-1:0] pd;
    logic                   zero;
    logic                   rev;
  } lane_res_t;

endpackage

>>> sv/tpsd_cfg_regs.sv
// ----------------------------------------------------------------------------
// tpsd_cfg_regs
// APB register file holding the three PID gains and the integral limit.
// ----------------------------------------------------------------------------
module tpsd_cfg_regs import tpsd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [PADDR_W-1:0]    paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output cfg_t                  cfg
);

  reg_idx_t idx;
  logic     wr;

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[PADDR_W-1:ADDR_LSB]);
  assign wr     = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.kp    <= PROP_GAIN_RST;
      cfg.ki    <= INT_GAIN_RST;
      cfg.kd    <= DERIV_GAIN_RST;
      cfg.limit <= INT_LIMIT_RST;
    end else if (wr) begin
      unique case (idx)
        REG_PROP_GAIN:  cfg.kp    <= pwdata[GAIN_W-1:0];
        REG_INT_GAIN:   cfg.ki    <= pwdata[GAIN_W-1:0];
        REG_DERIV_GAIN: cfg.kd    <= pwdata[GAIN_W-1:0];
        REG_INT_LIMIT:  cfg.limit <= pwdata[LIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_PROP_GAIN:  prdata = APB_DATA_W'(cfg.kp);
      REG_INT_GAIN:   prdata = APB_DATA_W'(cfg.ki);
      REG_DERIV_GAIN: prdata = APB_DATA_W'(cfg.kd);
      REG_INT_LIMIT:  prdata = APB_DATA_W'(cfg.limit);
      default:        prdata = '0;
    endcase
  end

endmodule

>>> sv/tpsd_pipe_ctrl.sv
// ----------------------------------------------------------------------------
// tpsd_pipe_ctrl
// Valid tracking and stage load enables for the shared lane pipeline.
// ----------------------------------------------------------------------------
module tpsd_pipe_ctrl import tpsd_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      s_tvalid,
  output logic      s_tready,
  output logic      m_tvalid,
  input  logic      m_tready,
  output pipe_ctl_t ctl
);

  logic [N_STG-1:0] valid;
  logic [N_STG-1:0] ready;

  // A stage can load when it is empty or when its content moves on.
  always_comb begin
    ready[N_STG-1] = ~valid[N_STG-1] | m_tready;
    for (int k = N_STG - 2; k >= 0; k--) begin
      ready[k] = ~valid[k] | ready[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      if (ready[0]) begin
        valid[0] <= s_tvalid;
      end
      for (int k = 1; k < N_STG; k++) begin
        if (ready[k]) begin
          valid[k] <= valid[k-1];
        end
      end
    end
  end

  assign s_tready   = ready[0];
  assign m_tvalid   = valid[N_STG-1];
  assign ctl.take   = s_tvalid & ready[0];
  assign ctl.ld2    = ready[1];
  assign ctl.ld3    = ready[2];
  assign ctl.ld_out = ready[3];

endmodule

>>> sv/tpsd_lane.sv
// ----------------------------------------------------------------------------
// tpsd_lane
// One wheel's PID datapath: error and integral state, split gain products
// and partial sums.
// ----------------------------------------------------------------------------
module tpsd_lane import tpsd_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  pipe_ctl_t        ctl,
  input  cfg_t             cfg,
  input  logic [SPD_W-1:0] meas_speed,
  input  logic [SPD_W-1:0] cmd_speed,
  input  logic             reverse,
  output lane_res_t        res
);

  localparam logic signed [ACC_W-1:0] SUM_MIN = {2'b11, {(SUM_W - 1){1'b0}}};

  // Per-wheel state.
  logic signed [SUM_W-1:0] error_sum;
  logic signed [ERR_W-1:0] prev_error;

  logic signed [ERR_W-1:0] err;
  logic signed [DIF_W-1:0] diff;
  logic signed [ACC_W-1:0] acc_raw;
  logic signed [ACC_W-1:0] acc_lo;
  logic signed [ACC_W-1:0] limit_x;
  logic signed [SUM_W-1:0] error_sum_next;

  // Stage 1 registers.
  logic signed [ERR_W-1:0] e_q;
  logic signed [DIF_W-1:0] d_q;
  logic signed [SUM_W-1:0] acc_q;
  logic                    zero_q;
  logic                    rev_q;

  // Stage 2 registers.
  logic signed [PE_W-1:0]  pe_q;
  logic signed [DE_W-1:0]  de_q;
  logic        [IL_W-1:0]  il_q;
  logic signed [IH_W-1:0]  ih_q;
  logic                    zero_q2;
  logic                    rev_q2;

  // Stage 3 registers.
  logic signed [TI_W-1:0]  ti_q;
  logic signed [PD_W-1:0]  pd_q;
  logic                    zero_q3;
  logic                    rev_q3;

  logic signed [PE_W-1:0]     kp_x;
  logic signed [PE_W-1:0]     e_x;
  logic signed [DE_W-1:0]     kd_x;
  logic signed [DE_W-1:0]     d_x;
  logic        [IL_W-1:0]     ki_lo_x;
  logic        [IL_W-1:0]     acc_lo_x;
  logic signed [IH_W-1:0]     ki_hi_x;
  logic signed [IH_W-1:0]     acc_hi_x;

  always_comb begin
    err     = $signed({1'b0, cmd_speed}) - $signed({1'b0, meas_speed});
    diff    = DIF_W'(err) - DIF_W'(prev_error);
    acc_raw = ACC_W'(error_sum) + ACC_W'(err);
    acc_lo  = (acc_raw < SUM_MIN) ? SUM_MIN : acc_raw;
    limit_x = $signed({{(ACC_W - LIM_W){1'b0}}, cfg.limit});
    // The upper clamp applies to the stored sum only, after the term is formed.
    if (acc_lo > limit_x) begin
      error_sum_next = $signed({{(SUM_W - LIM_W){1'b0}}, cfg.limit});
    end else begin
      error_sum_next = acc_lo[SUM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      error_sum  <= '0;
      prev_error <= '0;
    end else if (ctl.take) begin
      error_sum  <= error_sum_next;
      prev_error <= err;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.take) begin
      e_q    <= err;
      d_q    <= diff;
      acc_q  <= acc_lo[SUM_W-1:0];
      zero_q <= (cmd_speed == '0);
      rev_q  <= reverse;
    end
  end

  // The integral product is split into a low unsigned and a high signed half.
  always_comb begin
    kp_x     = PE_W'($signed({1'b0, cfg.kp}));
    e_x      = PE_W'(e_q);
    kd_x     = DE_W'($signed({1'b0, cfg.kd}));
    d_x      = DE_W'(d_q);
    ki_lo_x  = IL_W'(cfg.ki);
    acc_lo_x = IL_W'(acc_q[ACC_LO_W-1:0]);
    ki_hi_x  = IH_W'($signed({1'b0, cfg.ki}));
    acc_hi_x = IH_W'($signed(acc_q[SUM_W-1:ACC_LO_W]));
  end

  always_ff @(posedge clk) begin
    if (ctl.ld2) begin
      pe_q    <= kp_x * e_x;
      de_q    <= kd_x * d_x;
      il_q    <= ki_lo_x * acc_lo_x;
      ih_q    <= ki_hi_x * acc_hi_x;
      zero_q2 <= zero_q;
      rev_q2  <= rev_q;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.ld3) begin
      ti_q    <= (TI_W'(ih_q) <<< ACC_LO_W) + $signed(TI_W'(il_q));
      pd_q    <= PD_W'(pe_q) + PD_W'(de_q);
      zero_q3 <= zero_q2;
      rev_q3  <= rev_q2;
    end
  end

  assign res.ti   = ti_q;
  assign res.pd   = pd_q;
  assign res.zero = zero_q3;
  assign res.rev  = rev_q3;

endmodule

>>> sv/tpsd_merge.sv
// ----------------------------------------------------------------------------
// tpsd_merge
// Final sum, floor and saturation per lane, direction routing, and the
// output register that packs all wheels into one result.
// ----------------------------------------------------------------------------
module tpsd_merge import tpsd_pkg::*; (
  input  logic                              clk,
  input  pipe_ctl_t                         ctl,
  input  lane_res_t [WHEEL_COUNT-1:0]       res,
  output logic      [OUT_TDATA_W-1:0]       m_tdata
);

  logic [OUT_FIELD_W-1:0] packed_out;

  always_comb begin
    logic signed [TOT_W-1:0] tot;
    logic        [Q_W-1:0]   q;
    logic        [PWM_BITS-1:0] duty;
    packed_out = '0;
    for (int w = 0; w < WHEEL_COUNT; w++) begin
      tot = TOT_W'(res[w].ti) + TOT_W'(res[w].pd);
      q   = tot[TOT_W-1:FRAC_W];
      if (tot[TOT_W-1]) begin
        duty = '0;
      end else if (|q[Q_W-1:PWM_BITS]) begin
        duty = '1;
      end else begin
        duty = q[PWM_BITS-1:0];
      end
      // A zero command silences both outputs of the wheel.
      if (!res[w].zero) begin
        if (res[w].rev) begin
          packed_out[w*OUT_LANE_W+PWM_BITS +: PWM_BITS] = duty;
        end else begin
          packed_out[w*OUT_LANE_W +: PWM_BITS] = duty;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.ld_out) begin
      m_tdata <= OUT_TDATA_W'(packed_out);
    end
  end

endmodule

>>> sv/three_wheel_pid_speed_drive_top.sv
// ----------------------------------------------------------------------------
// three_wheel_pid_speed_drive_top
// Three-wheel PID speed controller with integral anti-windup.
// ----------------------------------------------------------------------------
// Each request carries one control tick for all wheels; every wheel has its
// own PID lane and all lanes run side by side, so the block takes one request
// per clock while the output is not stalled and returns one result for each.
// A request passes through the lane pipeline: the error and integral update,
// the split gain multiplies, the partial sums, and the output register where
// the lanes are saturated and packed. Gains and the integral limit live in
// APB registers at byte addresses 0, 8, 16 and 24 and are to be changed only
// while no request is in flight.
module three_wheel_pid_speed_drive_top import tpsd_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  // s_tdata from bit 0: per wheel A, B, C: meas_speed (15), cmd_speed (15),
  // reverse (1); zero padding on top.
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  // m_tdata from bit 0: per wheel A, B, C: fwd_pwm (8), rev_pwm (8).
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [PADDR_W-1:0]     paddr,
  input  logic [APB_DATA_W-1:0]  pwdata,
  output logic [APB_DATA_W-1:0]  prdata,
  output logic                   pready
);

  cfg_t                        cfg;
  pipe_ctl_t                   ctl;
  lane_res_t [WHEEL_COUNT-1:0] res;

  tpsd_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  tpsd_pipe_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .ctl      (ctl)
  );

  for (genvar w = 0; w < WHEEL_COUNT; w++) begin : g_lane
    tpsd_lane u_lane (
      .clk        (clk),
      .rst        (rst),
      .ctl        (ctl),
      .cfg        (cfg),
      .meas_speed (s_tdata[w*IN_LANE_W +: SPD_W]),
      .cmd_speed  (s_tdata[w*IN_LANE_W+SPD_W +: SPD_W]),
      .reverse    (s_tdata[w*IN_LANE_W+2*SPD_W]),
      .res        (res[w])
    );
  end

  tpsd_merge u_merge (
    .clk     (clk),
    .ctl     (ctl),
    .res     (res),
    .m_tdata (m_tdata)
  );

endmodule

>>> sv/tpsd_checker.sv
// ----------------------------------------------------------------------------
// tpsd_checker
// Port-level checks of the speed drive, bound to the top level.
// ----------------------------------------------------------------------------
module tpsd_checker import tpsd_pkg::*; (
  input logic                   clk,
  input logic                   rst,
  input logic                   s_tready,
  input logic                   m_tvalid,
  input logic                   m_tready,
  input logic [OUT_TDATA_W-1:0] m_tdata
);

  // A stalled result keeps its value.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // Reset empties the output register.
  a_reset: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result present right after reset");

  // With nothing waiting at the output, the whole pipeline can move.
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with an empty output");

  // At most one of a wheel's two PWM outputs is driven.
  for (genvar w = 0; w < WHEEL_COUNT; w++) begin : g_wheel
    a_one_dir: assert property (@(posedge clk) disable iff (rst)
      m_tvalid |-> (m_tdata[w*OUT_LANE_W +: PWM_BITS] == '0) ||
                   (m_tdata[w*OUT_LANE_W+PWM_BITS +: PWM_BITS] == '0))
      else $error("forward and reverse driven together");
  end

endmodule

bind three_wheel_pid_speed_drive_top tpsd_checker u_tpsd_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
